>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define LPHI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition never holds at a clock edge outside reset.
`define LPHI_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/lphi_pkg.sv
// Types and constants of the linear probing hash insert unit.
package lphi_pkg;

  localparam int unsigned TableSize = 16;
  localparam int unsigned SlotW     = $clog2(TableSize);
  localparam int unsigned ValueW    = 32;

  localparam logic KindInsert = 1'b0;
  localparam logic KindRead   = 1'b1;

  localparam logic [1:0] StHome   = 2'd0;
  localparam logic [1:0] StProbed = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;
  localparam logic [1:0] StRead   = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] value;
    logic [SlotW-1:0]  read_slot;
  } lphi_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  slot;
    logic [ValueW-1:0] slot_value;
    logic              slot_valid;
  } lphi_out_t;

  typedef struct packed {
    logic load_req;   // capture the accepted input word
    logic exec;       // search, write table, read table
    logic load_out;   // move the result into the output register
  } lphi_cmd_t;

endpackage

>>> rtl/lphi_ctrl.sv
// Controller: sequences accept, execute and result load, owns the handshakes.
module lphi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lphi_pkg::lphi_cmd_t cmd_o
);
  import lphi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_DONE) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_WORK;
      end
      S_WORK: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = accept ? S_WORK : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load_req = accept;
    cmd_o.exec     = (state_q == S_WORK);
    cmd_o.load_out = (state_q == S_DONE) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/lphi_dpath.sv
// Datapath: request register, slot valid bits, value memory, free slot search, result.
module lphi_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lphi_pkg::lphi_cmd_t cmd_i,
  input  lphi_pkg::lphi_in_t  in_word_i,
  output lphi_pkg::lphi_out_t out_word_o,
  output logic                table_full_o
);
  import lphi_pkg::*;

  lphi_in_t               req_q;
  logic [TableSize-1:0]   used_q;
  logic [ValueW-1:0]      mem [TableSize];
  logic [ValueW-1:0]      mem_rd_q;
  logic                   rd_used_q;

  logic [1:0]             res_status_q;
  logic [SlotW-1:0]       res_slot_q;
  logic [ValueW-1:0]      res_value_q;
  logic                   res_valid_q;
  logic                   res_read_q;
  lphi_out_t              out_q;

  logic [SlotW-1:0]       home;
  logic [2*TableSize-1:0] dbl;
  logic [TableSize-1:0]   rot;
  logic [SlotW-1:0]       off;
  logic [SlotW-1:0]       free_slot;
  logic                   any_free;
  logic                   do_insert;
  logic                   do_read;

  assign home      = req_q.value[SlotW-1:0];
  assign any_free  = ~&used_q;
  assign do_insert = cmd_i.exec && (req_q.kind == KindInsert) && any_free;
  assign do_read   = cmd_i.exec && (req_q.kind == KindRead);

  // Circular priority encode: first empty slot at or above home, wrapping.
  always_comb begin
    dbl = {used_q, used_q} >> home;
    rot = dbl[TableSize-1:0];
    off = '0;
    for (int k = TableSize - 1; k >= 0; k--) begin
      if (!rot[k]) off = SlotW'(k);
    end
    free_slot = home + off;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (do_insert) begin
      used_q[free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) mem[free_slot] <= req_q.value;
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      mem_rd_q  <= mem[req_q.read_slot];
      rd_used_q <= used_q[req_q.read_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_read_q <= (req_q.kind == KindRead);
      if (req_q.kind == KindRead) begin
        res_status_q <= StRead;
        res_slot_q   <= req_q.read_slot;
        res_value_q  <= '0;
        res_valid_q  <= 1'b0;
      end else if (any_free) begin
        res_status_q <= (off == '0) ? StHome : StProbed;
        res_slot_q   <= free_slot;
        res_value_q  <= req_q.value;
        res_valid_q  <= 1'b1;
      end else begin
        res_status_q <= StFull;
        res_slot_q   <= '0;
        res_value_q  <= '0;
        res_valid_q  <= 1'b0;
      end
    end
  end

  // Output word register; empty slots read as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status     <= res_status_q;
      out_q.slot       <= res_slot_q;
      out_q.slot_value <= res_read_q ? (rd_used_q ? mem_rd_q : '0) : res_value_q;
      out_q.slot_valid <= res_read_q ? rd_used_q : res_valid_q;
    end
  end

  assign out_word_o   = out_q;
  assign table_full_o = ~any_free;

endmodule

>>> rtl/linear_probe_hash_insert_unit.sv
// An accepted word passes through the request register, the result registers and the output register.
// The work state runs the circular free slot search and the table write or read; the done state
// loads the output register once the previous result word has been taken.
// A new word is accepted in the same cycle the previous result is loaded.
// Reset clears the slot valid bits at once; stored values are undefined until written.
`include "assert_macros.svh"

module linear_probe_hash_insert_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lphi_pkg::lphi_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lphi_pkg::lphi_out_t out_word_o
);
  import lphi_pkg::*;

  lphi_cmd_t cmd;
  logic      table_full;
  logic      in_accept;
  logic      out_full;
  logic      out_stored;
  logic      out_empty;

  assign in_accept  = in_valid_i && in_ready_o;
  assign out_full   = out_valid_o && (out_word_o.status == StFull);
  assign out_stored = out_valid_o &&
                      (out_word_o.status == StHome || out_word_o.status == StProbed);
  assign out_empty  = out_valid_o && !out_word_o.slot_valid;

  lphi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lphi_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_word_i    (in_word_i),
    .out_word_o   (out_word_o),
    .table_full_o (table_full)
  );

  `LPHI_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_accept |=> !in_ready_o, "ready after accept")
  `LPHI_ASSERT(a_full_stays_full, clk_i, rst_ni, out_full |-> table_full, "full with free slot")
  `LPHI_NEVER(a_stored_valid, clk_i, rst_ni, out_stored && !out_word_o.slot_valid, "stored not valid")
  `LPHI_NEVER(a_empty_zero, clk_i, rst_ni, out_empty && out_word_o.slot_value != '0, "empty nonzero")

endmodule

>>> sim/linear_probe_hash_insert_unit_test.sv
// Testbench for linear_probe_hash_insert_unit: queued words, a bit-true predictor, result check.
module linear_probe_hash_insert_unit_test;
  import lphi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  lphi_in_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  lphi_out_t out_word_o;

  linear_probe_hash_insert_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  // Predicted table contents.
  logic [ValueW-1:0] tbl_value [TableSize];
  logic              tbl_used  [TableSize];

  lphi_in_t  pending_words [$];
  lphi_out_t expected_words [$];

  int err_count   = 0;
  int n_results   = 0;
  int n_home      = 0;
  int n_probed    = 0;
  int n_full      = 0;
  int n_reads     = 0;
  int send_gap    = 0;
  int send_calm   = 0;
  int stall_left  = 0;
  int stall_calm  = 0;

  lphi_out_t want;
  lphi_out_t got;

  initial begin
    for (int i = 0; i < TableSize; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_value[i] = '0;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one accepted word to the predicted table and returns the result word.
  function automatic lphi_out_t hash_table_apply(lphi_in_t w);
    lphi_out_t        res;
    logic [SlotW-1:0] home;
    logic [SlotW-1:0] s;
    res = '0;
    if (w.kind == KindRead) begin
      res.status = StRead;
      res.slot   = w.read_slot;
      if (tbl_used[w.read_slot]) begin
        res.slot_value = tbl_value[w.read_slot];
        res.slot_valid = 1'b1;
      end
      n_reads++;
      return res;
    end
    home = SlotW'(w.value % TableSize);
    // circular search, home first, then upward with wrap
    for (int k = 0; k < TableSize; k++) begin
      s = home + SlotW'(k);
      if (!tbl_used[s]) begin
        tbl_used[s]    = 1'b1;
        tbl_value[s]   = w.value;
        res.status     = (k == 0) ? StHome : StProbed;
        res.slot       = s;
        res.slot_value = w.value;
        res.slot_valid = 1'b1;
        if (k == 0) n_home++;
        else n_probed++;
        return res;
      end
    end
    res.status = StFull;
    n_full++;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, n_results, msg);
    err_count++;
  endtask

  task automatic queue_insert(logic [ValueW-1:0] v);
    lphi_in_t w;
    w.kind      = KindInsert;
    w.value     = v;
    w.read_slot = SlotW'($urandom_range(0, TableSize - 1));
    pending_words.push_back(w);
  endtask

  task automatic queue_read(int s);
    lphi_in_t w;
    w.kind      = KindRead;
    w.value     = $urandom;
    w.read_slot = SlotW'(s);
    pending_words.push_back(w);
  endtask

  // Driver: one word at a time from pending_words, random gap after each accept.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) expected_words.push_back(hash_table_apply(in_word_i));
      if (in_valid_i && !in_ready_o) begin
        // hold word until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction, stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = out_word_o;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", got));
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
          if (got.slot_value !== want.slot_value)
            report_mismatch($sformatf("slot_value %h, want %h", got.slot_value,
                                      want.slot_value));
          if (got.slot_valid !== want.slot_valid)
            report_mismatch($sformatf("slot_valid %b, want %b", got.slot_valid,
                                      want.slot_valid));
        end
        n_results++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) stall_left = pick_gap(stall_calm);
      end
    end
  end

  initial begin
    // directed: home hits, probing, wrap past the top, extreme values
    queue_insert(32'h0000_0000);
    queue_insert(32'hFFFF_FFFF);
    queue_insert(32'h0000_0010);
    queue_insert(32'h0000_001F);
    queue_insert(32'hFFFF_FFF0);
    queue_read(0);
    queue_read(1);
    queue_read(2);
    queue_read(3);
    queue_read(15);
    queue_insert(32'h8000_0005);
    queue_read(5);
    // ten more inserts fill the last free slots
    for (int i = 0; i < 10; i++) queue_insert($urandom);
    // table is now full
    queue_insert(32'hFFFF_FFFF);
    queue_insert(32'h0000_0000);
    // random: every slot is written, so any read index is fair
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 99) < 60) queue_read($urandom_range(0, TableSize - 1));
      else queue_insert($urandom);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d result words: %0d reads, %0d stored at home, %0d after probing,",
             n_results, n_reads, n_home, n_probed);
    $display("%0d inserts rejected on a full table; %0d mismatches.", n_full, err_count);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d words pending, %0d results expected",
             pending_words.size(), expected_words.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
